>>> rtl/sdf_pkg.sv
// Package for the stable duplicate filter: sizes and the item record
// that moves from cell to cell along the compare chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_W     = 32;
  // internal count reaches TABLE_DEPTH; the reported count is 7 bits wide
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_CNT_W   = 7;

  typedef struct packed {
    logic                      vld;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      found;  // matched an entry or claimed a cell
    logic                      kept;   // claimed a cell
    logic [CNT_W-1:0]          cnt;    // occupied cells seen so far
  } sdf_item_t;

endpackage

`default_nettype wire

>>> rtl/sdf_cell.sv
// One cell of the compare chain: holds one table entry and its occupied
// flag, checks the passing item against it. Depends on sdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdf_cell
  import sdf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sdf_item_t i_item,
  output sdf_item_t      o_item
);

  logic                      occ_r;
  logic                      occ_nxt;
  logic signed [VALUE_W-1:0] entry_r;
  sdf_item_t                 item_r;
  sdf_item_t                 item_nxt;
  logic                      match;
  logic                      claim;

  // occupied cells always form a prefix, so the first free cell is the append slot
  assign match = i_item.vld & occ_r & (entry_r == i_item.value);
  assign claim = i_item.vld & ~occ_r & ~i_item.found;

  always_comb begin
    item_nxt       = i_item;
    item_nxt.found = i_item.found | match | claim;
    item_nxt.kept  = i_item.kept | claim;
    item_nxt.cnt   = i_item.cnt + CNT_W'(occ_r | claim);
  end

  always_comb begin
    occ_nxt = occ_r;
    if (i_item.vld && i_item.last) begin
      // end of set: the next set's items trail this one and see a free cell
      occ_nxt = 1'b0;
    end else if (claim) begin
      occ_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= 1'b0;
      item_r.vld <= 1'b0;
    end else begin
      occ_r      <= occ_nxt;
      item_r.vld <= i_item.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      entry_r <= i_item.value;
    end
    item_r.value <= item_nxt.value;
    item_r.last  <= item_nxt.last;
    item_r.found <= item_nxt.found;
    item_r.kept  <= item_nxt.kept;
    item_r.cnt   <= item_nxt.cnt;
  end

  assign o_item = item_r;

endmodule

`default_nettype wire

>>> rtl/sdf_chain.sv
// Row of TABLE_DEPTH compare cells; each item moves one cell per cycle.
// Depends on sdf_pkg and sdf_cell.
`timescale 1ns / 1ps
`default_nettype none

module sdf_chain
  import sdf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sdf_item_t i_item,
  output sdf_item_t      o_item
);

  sdf_item_t link [0:TABLE_DEPTH];

  assign link[0] = i_item;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    sdf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .i_item (link[g]),
      .o_item (link[g+1])
    );
  end

  assign o_item = link[TABLE_DEPTH];

endmodule

`default_nettype wire

>>> rtl/stable_duplicate_filter_top.sv
// Each item passes through all TABLE_DEPTH (64) registered cells of the chain.
// Throughput: one item per cycle while busy is low; busy is high in reset
// and until the first clock edge with rst_n high. Items of later sets may
// follow directly behind an item with in_last set.
// Reset: synchronous, active low; empties the table and drops in-flight items.
// Depends on sdf_pkg and sdf_chain.
`timescale 1ns / 1ps
`default_nettype none

module stable_duplicate_filter_top
  import sdf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic                      in_last,
  output      logic                      out_valid,
  output      logic signed [VALUE_W-1:0] out_value_out,
  output      logic                      out_kept,
  output      logic [OUT_CNT_W-1:0]      out_distinct_count,
  output      logic                      out_overflow,
  output      logic                      out_last_out
);

  localparam int WIDE_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
  localparam logic [WIDE_W-1:0] CNT_MAX = WIDE_W'((1 << OUT_CNT_W) - 1);
  localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(TABLE_DEPTH);
  localparam logic [OUT_CNT_W-1:0] FULL_SHOWN =
    (TABLE_DEPTH > (1 << OUT_CNT_W) - 1) ? OUT_CNT_W'((1 << OUT_CNT_W) - 1)
                                         : OUT_CNT_W'(TABLE_DEPTH);

  logic            busy_r;
  sdf_item_t       in_item;
  sdf_item_t       res_item;
  logic [WIDE_W-1:0] cnt_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  always_comb begin
    in_item       = '0;
    in_item.vld   = start & ~busy_r;
    in_item.value = in_value;
    in_item.last  = in_last;
  end

  sdf_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_item (in_item),
    .o_item (res_item)
  );

  assign cnt_wide = WIDE_W'(res_item.cnt);

  assign out_valid          = res_item.vld;
  assign out_value_out      = res_item.value;
  assign out_kept           = res_item.kept;
  assign out_overflow       = ~res_item.found;
  assign out_last_out       = res_item.last;
  assign out_distinct_count = (cnt_wide > CNT_MAX) ? CNT_MAX[OUT_CNT_W-1:0]
                                                   : cnt_wide[OUT_CNT_W-1:0];

  a_kept_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_kept && out_overflow))
    else $error("kept and overflow both set");

  a_ovf_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_distinct_count == FULL_SHOWN))
    else $error("overflow reported with table not full");

  a_kept_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kept) |-> (out_distinct_count != '0))
    else $error("kept item with zero count");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TABLE_DEPTH out_valid)
    else $error("result missing after chain latency");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_wide <= DEPTH_W))
    else $error("count beyond table depth");

endmodule

`default_nettype wire

>>> dv/stable_duplicate_filter_top_test.sv
// Self-checking testbench for stable_duplicate_filter_top: drives sets of values,
// predicts kept/dropped, count, overflow and last per item, checks every result.
// Depends on sdf_pkg and the filter RTL.
`timescale 1ns / 1ps

module stable_duplicate_filter_top_test;
  import sdf_pkg::*;

  localparam int ITEM_GOAL = 1150;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      kept;
    logic [OUT_CNT_W-1:0]      cnt;
    logic                      ovf;
    logic                      last;
  } dedup_result_t;

  logic                      clk      = 1'b0;
  logic                      rst_n    = 1'b0;
  logic                      start    = 1'b0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      in_last  = 1'b0;
  logic                      busy;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value_out;
  logic                      out_kept;
  logic [OUT_CNT_W-1:0]      out_distinct_count;
  logic                      out_overflow;
  logic                      out_last_out;

  // predictor state: distinct values of the open set
  logic [VALUE_W-1:0] seen_vals [TABLE_DEPTH];
  int                 seen_cnt = 0;
  dedup_result_t      pending_results[$];

  bit idle_en    = 1'b1;
  int mismatches = 0;
  int n_items    = 0;
  int n_sets     = 0;
  int n_dropped  = 0;
  int n_overflow = 0;
  int n_checked  = 0;

  stable_duplicate_filter_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_value          (in_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_value_out     (out_value_out),
    .out_kept          (out_kept),
    .out_distinct_count(out_distinct_count),
    .out_overflow      (out_overflow),
    .out_last_out      (out_last_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("stable_duplicate_filter_top_test NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic dedup_result_t predict_dedup(input logic [VALUE_W-1:0] v,
                                                  input logic l);
    dedup_result_t r;
    bit present;
    present = 1'b0;
    for (int i = 0; i < seen_cnt; i++)
      if (seen_vals[i] == v) present = 1'b1;
    r.value = v;
    r.kept  = 1'b0;
    r.ovf   = 1'b0;
    r.last  = l;
    if (!present) begin
      if (seen_cnt < TABLE_DEPTH) begin
        seen_vals[seen_cnt] = v;
        seen_cnt++;
        r.kept = 1'b1;
      end else begin
        r.ovf = 1'b1;
      end
    end
    r.cnt = (seen_cnt > 127) ? 7'd127 : OUT_CNT_W'(seen_cnt);
    if (l) seen_cnt = 0;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one transfer; start stays high afterwards unless the next call idles
  task automatic send_item(input logic [VALUE_W-1:0] v, input logic l);
    int gap;
    dedup_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    in_last  <= l;
    do @(posedge clk); while (busy !== 1'b0);
    r = predict_dedup(v, l);
    pending_results.push_back(r);
    n_items++;
    if (l) n_sets++;
    if (!r.kept) n_dropped++;
    if (r.ovf) n_overflow++;
  endtask

  always @(posedge clk) begin
    dedup_result_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d", out_value_out));
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (out_value_out !== e.value)
          report_mismatch($sformatf("value %h, want %h", out_value_out, e.value));
        if (out_kept !== e.kept)
          report_mismatch($sformatf("kept %b, want %b (value %h)", out_kept, e.kept,
                                    e.value));
        if (out_distinct_count !== e.cnt)
          report_mismatch($sformatf("count %0d, want %0d (value %h)",
                                    out_distinct_count, e.cnt, e.value));
        if (out_overflow !== e.ovf)
          report_mismatch($sformatf("overflow %b, want %b (value %h)", out_overflow,
                                    e.ovf, e.value));
        if (out_last_out !== e.last)
          report_mismatch($sformatf("last %b, want %b (value %h)", out_last_out,
                                    e.last, e.value));
      end
    end
  end

  // extremes, sign boundary, alternating bits, repeats, one-item set
  task automatic test_directed();
    send_item(32'h0000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    // the finished set must not leak into the next one
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b1);
  endtask

  // fill all cells, then new values overflow while repeats stay plain drops
  task automatic test_table_full();
    logic [VALUE_W-1:0] base;
    base = $urandom;
    for (int i = 0; i < TABLE_DEPTH; i++) send_item(base + i, 1'b0);
    send_item(base + TABLE_DEPTH, 1'b0);
    send_item(base + TABLE_DEPTH + 7, 1'b0);
    send_item(base + 5, 1'b0);
    send_item(base + TABLE_DEPTH - 1, 1'b0);
    send_item(base - 1, 1'b1);
    // exactly full, closed by a repeat
    base = $urandom;
    for (int i = 0; i < TABLE_DEPTH; i++) send_item(base ^ i, 1'b0);
    send_item(base, 1'b1);
    send_item(base, 1'b1);
  endtask

  // short sets, no idling on the input side
  task automatic test_back_to_back();
    int len;
    logic [VALUE_W-1:0] v;
    idle_en = 1'b0;
    for (int s = 0; s < 30; s++) begin
      len = $urandom_range(1, 5);
      v = $urandom;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 1)) v = $urandom;
        send_item(v, k == len - 1);
      end
    end
    idle_en = 1'b1;
  endtask

  // sets drawn mostly from a small pool so repeats are frequent; some sets are
  // long with a wide pool so the table fills up
  task automatic test_random_sets();
    logic [VALUE_W-1:0] pool [$];
    int len, pool_sz;
    logic [VALUE_W-1:0] v;
    while (n_items < ITEM_GOAL) begin
      idle_en = ($urandom_range(0, 3) != 0);
      pool.delete();
      if ($urandom_range(0, 9) == 0) begin
        len     = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 20);
        pool_sz = $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 16);
      end else begin
        len     = $urandom_range(1, 24);
        pool_sz = $urandom_range(1, 12);
      end
      for (int k = 0; k < pool_sz; k++) pool.push_back($urandom);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 4) == 0) v = $urandom;
        else v = pool[$urandom_range(0, pool_sz - 1)];
        send_item(v, k == len - 1);
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    int guard;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_back_to_back();
    test_random_sets();
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 4 * TABLE_DEPTH + 100) begin
      @(posedge clk);
      guard++;
    end
    // catch stray strobes after the last expected result
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d items in %0d sets, %0d results checked", n_items, n_sets,
             n_checked);
    $display("%0d dropped as repeats or overflow, %0d overflowed a full table",
             n_dropped, n_overflow);
    if (mismatches == 0) begin
      $display("stable_duplicate_filter_top_test OK");
    end else begin
      $display("stable_duplicate_filter_top_test NOT OK");
    end
    $finish;
  end

endmodule
